// ----- sv/imgf_pkg.sv -----
// ----------------------------------------------------------------------------
// imgf_pkg
// Shared types and constants for the interval merge and gap finder: span
// record of one sorting cell, control groups and the top-level state codes.
// ----------------------------------------------------------------------------
package imgf_pkg;

    localparam int MAX_SPANS = 64;
    localparam int CNT_W     = $clog2(MAX_SPANS + 1);
    localparam int DATA_W    = 32;

    // One closed interval held by a cell; lo <= hi after load
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
    } t_span;

    // Row-wide cell control: insert a new span or shift toward the head
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

    // Gap emitter control
    typedef struct packed {
        logic step;
        logic finish;
        logic ovf;
    } t_emit_ctl;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ----- sv/imgf_cell.sv -----
// ----------------------------------------------------------------------------
// imgf_cell
// One cell of the sorting row. Holds one span; on insert it keeps, takes
// the new span or takes its lower neighbor's span so the row stays ordered
// by start; on drain it takes its upper neighbor's span.
// ----------------------------------------------------------------------------
module imgf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imgf_pkg::t_cell_ctl i_ctl,
    input  imgf_pkg::t_span     i_new,
    input  imgf_pkg::t_span     i_prev,
    input  imgf_pkg::t_span     i_next,
    input  logic                i_prev_lt,
    output imgf_pkg::t_span     o_span,
    output logic                o_lt
);

    imgf_pkg::t_span r_span;
    imgf_pkg::t_span n_span;

    // An empty cell sorts after every span
    assign o_lt   = !r_span.vld || ($signed(i_new.lo) < $signed(r_span.lo));
    assign o_span = r_span;

    // Select the next content of the cell
    always_comb begin
        n_span = r_span;
        if (i_ctl.insert) begin
            if (o_lt && !i_prev_lt) begin
                n_span = i_new;
            end else if (o_lt) begin
                n_span = i_prev;
            end
        end else if (i_ctl.drain) begin
            n_span = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span.vld <= 1'b0;
        end else begin
            r_span <= n_span;
        end
    end

endmodule

// ----- sv/imgf_emit.sv -----
// ----------------------------------------------------------------------------
// imgf_emit
// Merge unit and output stage. Takes the sorted spans one per step, keeps
// the running end of the current merged interval, holds the latest gap back
// until it is known whether another follows, and drives the result beat.
// ----------------------------------------------------------------------------
module imgf_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  imgf_pkg::t_emit_ctl                i_ctl,
    input  imgf_pkg::t_span                    i_head,
    output logic                               o_adv,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [imgf_pkg::DATA_W-1:0] o_gap_low,
    output logic signed [imgf_pkg::DATA_W-1:0] o_gap_high,
    output logic                               o_gap_present,
    output logic                               o_capacity_overflow,
    output logic                               o_last_gap
);

    logic                        r_have;
    logic [imgf_pkg::DATA_W-1:0] r_cur_e;
    logic                        r_pend_v;
    logic [imgf_pkg::DATA_W-1:0] r_pend_lo;
    logic [imgf_pkg::DATA_W-1:0] r_pend_hi;

    logic                        r_out_v;
    logic [imgf_pkg::DATA_W-1:0] r_out_lo;
    logic [imgf_pkg::DATA_W-1:0] r_out_hi;
    logic                        r_out_gap;
    logic                        r_out_ovf;
    logic                        r_out_last;

    logic                        w_overlap;
    logic                        w_extend;

    // Output register is free or is being taken this cycle
    assign o_adv     = !r_out_v || i_ready;
    assign w_overlap = $signed(i_head.lo) <= $signed(r_cur_e);
    assign w_extend  = $signed(i_head.hi) > $signed(r_cur_e);

    // Control: merge state, pending gap, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_ctl.step) begin
                r_have <= 1'b1;
                if (r_have && !w_overlap) begin
                    r_pend_v <= 1'b1;
                    if (r_pend_v) begin
                        r_out_v <= 1'b1;
                    end
                end
            end else if (i_ctl.finish) begin
                r_have   <= 1'b0;
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    // Payload: running end, pending gap, output fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (!r_have) begin
                r_cur_e <= i_head.hi;
            end else if (w_overlap) begin
                if (w_extend) begin
                    r_cur_e <= i_head.hi;
                end
            end else begin
                r_cur_e   <= i_head.hi;
                r_pend_lo <= r_cur_e;
                r_pend_hi <= i_head.lo;
                // push the earlier gap out; it is not the last one
                if (r_pend_v) begin
                    r_out_lo   <= r_pend_lo;
                    r_out_hi   <= r_pend_hi;
                    r_out_gap  <= 1'b1;
                    r_out_ovf  <= i_ctl.ovf;
                    r_out_last <= 1'b0;
                end
            end
        end else if (i_ctl.finish) begin
            r_out_lo   <= r_pend_v ? r_pend_lo : '0;
            r_out_hi   <= r_pend_v ? r_pend_hi : '0;
            r_out_gap  <= r_pend_v;
            r_out_ovf  <= i_ctl.ovf;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid             = r_out_v;
    assign o_gap_low           = $signed(r_out_lo);
    assign o_gap_high          = $signed(r_out_hi);
    assign o_gap_present       = r_out_gap;
    assign o_capacity_overflow = r_out_ovf;
    assign o_last_gap          = r_out_last;

endmodule

// ----- sv/interval_merge_gap_finder_top.sv -----
// ----------------------------------------------------------------------------
// interval_merge_gap_finder_top
// Collects closed intervals, merges their union and reports the gaps in
// ascending order, one result beat per gap.
// ----------------------------------------------------------------------------
// Intervals load at one per cycle into a row of MAX_SPANS sorting cells that
// keep them ordered by start as they arrive; spans beyond capacity are dropped
// and flagged on every result of the set. After the beat marked final, the
// row shifts its spans one per cycle into the merge unit while the output is
// not stalled, then the merge unit finishes the set. No new interval is taken
// until the last result of the set has been handed to the output register.
// A set without gaps yields one result with gap_present low; last_gap marks
// the final result of each set.
// ----------------------------------------------------------------------------
module interval_merge_gap_finder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [imgf_pkg::DATA_W-1:0] i_span_start,
    input  logic signed [imgf_pkg::DATA_W-1:0] i_span_end,
    input  logic                               i_final_span,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [imgf_pkg::DATA_W-1:0] o_gap_low,
    output logic signed [imgf_pkg::DATA_W-1:0] o_gap_high,
    output logic                               o_gap_present,
    output logic                               o_capacity_overflow,
    output logic                               o_last_gap
);

    imgf_pkg::t_state                 r_state;
    imgf_pkg::t_state                 n_state;
    logic [imgf_pkg::CNT_W-1:0]       r_held_count;
    logic                             r_overflow_seen;

    logic                             w_accept;
    logic                             w_room;
    logic                             w_adv;
    imgf_pkg::t_span                  w_new;
    imgf_pkg::t_cell_ctl              w_cell_ctl;
    imgf_pkg::t_emit_ctl              w_emit_ctl;
    imgf_pkg::t_span                  w_span [imgf_pkg::MAX_SPANS];
    logic [imgf_pkg::MAX_SPANS-1:0]   w_lt;

    assign o_ready  = (r_state == imgf_pkg::ST_LOAD);
    assign w_accept = i_valid && o_ready;
    assign w_room   = r_held_count < imgf_pkg::CNT_W'(imgf_pkg::MAX_SPANS);

    // Order the endpoints on load
    always_comb begin
        w_new.vld = 1'b1;
        if (i_span_start > i_span_end) begin
            w_new.lo = i_span_end;
            w_new.hi = i_span_start;
        end else begin
            w_new.lo = i_span_start;
            w_new.hi = i_span_end;
        end
    end

    // Drive the row and the merge unit
    always_comb begin
        w_cell_ctl.insert = w_accept && w_room;
        w_cell_ctl.drain  = (r_state == imgf_pkg::ST_DRAIN) && w_adv && w_span[0].vld;
        w_emit_ctl.step   = w_cell_ctl.drain;
        w_emit_ctl.finish = (r_state == imgf_pkg::ST_DRAIN) && w_adv && !w_span[0].vld;
        w_emit_ctl.ovf    = r_overflow_seen;
    end

    // Sequence load and drain
    always_comb begin
        n_state = r_state;
        case (r_state)
            imgf_pkg::ST_LOAD: begin
                if (w_accept && i_final_span) begin
                    n_state = imgf_pkg::ST_DRAIN;
                end
            end
            imgf_pkg::ST_DRAIN: begin
                if (w_emit_ctl.finish) begin
                    n_state = imgf_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = imgf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= imgf_pkg::ST_LOAD;
            r_held_count    <= '0;
            r_overflow_seen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit_ctl.finish) begin
                r_held_count    <= '0;
                r_overflow_seen <= 1'b0;
            end else if (w_accept) begin
                if (w_room) begin
                    r_held_count <= r_held_count + 1'b1;
                end else begin
                    r_overflow_seen <= 1'b1;
                end
            end
        end
    end

    // Row of sorting cells, head at index 0
    genvar g;
    generate
        for (g = 0; g < imgf_pkg::MAX_SPANS; g++) begin : g_cell
            imgf_pkg::t_span w_prev;
            imgf_pkg::t_span w_next;
            logic            w_prev_lt;

            if (g == 0) begin : g_head
                assign w_prev    = '0;
                assign w_prev_lt = 1'b0;
            end else begin : g_body
                assign w_prev    = w_span[g-1];
                assign w_prev_lt = w_lt[g-1];
            end

            if (g == imgf_pkg::MAX_SPANS - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_span[g+1];
            end

            imgf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_cell_ctl),
                .i_new     (w_new),
                .i_prev    (w_prev),
                .i_next    (w_next),
                .i_prev_lt (w_prev_lt),
                .o_span    (w_span[g]),
                .o_lt      (w_lt[g])
            );
        end
    endgenerate

    imgf_emit u_emit (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_emit_ctl),
        .i_head              (w_span[0]),
        .o_adv               (w_adv),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_gap_low           (o_gap_low),
        .o_gap_high          (o_gap_high),
        .o_gap_present       (o_gap_present),
        .o_capacity_overflow (o_capacity_overflow),
        .o_last_gap          (o_last_gap)
    );

endmodule
